// ----- sv/assert_macros.svh -----
// Assertion macros used by the core RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold cons in the same cycle as ante.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Hold cons in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/pbea_pkg.sv -----
// Shared types and constants for the button edge and auto-repeat core.
package pbea_pkg;

    localparam int unsigned AXIS_W = 8;
    localparam int unsigned RAW_W  = 24;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned DIR_W  = WORD_W - RAW_W;
    localparam int unsigned CFG_W  = 8;

    localparam logic [CFG_W-1:0] CENTER_RST    = 8'd128;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 8'd64;
    localparam logic [CFG_W-1:0] DELAY_RST     = 8'd10;
    localparam logic [CFG_W-1:0] RELOAD_RST    = 8'd6;

    typedef enum logic [1:0] {
        CFG_CENTER    = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_DELAY     = 2'd2,
        CFG_RELOAD    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] center;
        logic [CFG_W-1:0] threshold;
    } t_stick_cfg;

endpackage

// ----- sv/pbea_dirs.sv -----
// Stick axis to direction bit decoder.
module pbea_dirs
    import pbea_pkg::*;
(
    input  t_stick_cfg        i_cfg,
    input  logic [AXIS_W-1:0] i_left_x,
    input  logic [AXIS_W-1:0] i_left_y,
    input  logic [AXIS_W-1:0] i_right_x,
    input  logic [AXIS_W-1:0] i_right_y,
    output logic [DIR_W-1:0]  o_dirs
);

    // {above center + threshold, below center - threshold}
    function automatic logic [1:0] axis_dir(
        input logic [AXIS_W-1:0] v,
        input t_stick_cfg        cfg
    );
        logic below;
        logic above;
        below = ({2'b00, v} + {2'b00, cfg.threshold}) < {2'b00, cfg.center};
        above = {1'b0, v} > ({1'b0, cfg.center} + {1'b0, cfg.threshold});
        return {above, below};
    endfunction

    logic [1:0] s_lx;
    logic [1:0] s_ly;
    logic [1:0] s_rx;
    logic [1:0] s_ry;

    always_comb begin
        s_lx = axis_dir(i_left_x, i_cfg);
        s_ly = axis_dir(i_left_y, i_cfg);
        s_rx = axis_dir(i_right_x, i_cfg);
        s_ry = axis_dir(i_right_y, i_cfg);
        o_dirs = {s_rx[0], s_ry[1], s_rx[1], s_ry[0],
                  s_lx[0], s_ly[1], s_lx[1], s_ly[0]};
    end

endmodule

// ----- sv/pad_button_edge_autorepeat_core.sv -----
// Controller poll edge detector with auto-repeat and long-hold outputs.
// Requests pass the input and result registers; the edge and counter update is one pass
// of logic. Throughput: 1 request per cycle while the result is not stalled.
// Input stall rises only when the input register is full and the result is stalled.
// Reset (synchronous, active low) empties both stages, clears the stored word and
// counters, and loads the configuration registers with their default values.
`include "assert_macros.svh"

module pad_button_edge_autorepeat_core
    import pbea_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,

    input  logic              i_valid,
    output logic              o_stall,
    input  logic [RAW_W-1:0]  i_raw_buttons,
    input  logic [AXIS_W-1:0] i_left_x,
    input  logic [AXIS_W-1:0] i_left_y,
    input  logic [AXIS_W-1:0] i_right_x,
    input  logic [AXIS_W-1:0] i_right_y,

    output logic              o_valid,
    input  logic              i_stall,
    output logic [WORD_W-1:0] o_button_word,
    output logic [WORD_W-1:0] o_pressed_bits,
    output logic [WORD_W-1:0] o_released_bits,
    output logic [WORD_W-1:0] o_repeat_bits,
    output logic [WORD_W-1:0] o_long_hold_bits
);

    t_stick_cfg        r_stick;
    logic [CFG_W-1:0]  r_delay;
    logic [CFG_W-1:0]  r_reload;

    logic              r_in_valid;
    logic [RAW_W-1:0]  r_raw;
    logic [AXIS_W-1:0] r_lx;
    logic [AXIS_W-1:0] r_ly;
    logic [AXIS_W-1:0] r_rx;
    logic [AXIS_W-1:0] r_ry;

    logic [WORD_W-1:0] r_stored_word;
    logic [CFG_W-1:0]  r_rep_cnt;
    logic [CFG_W-1:0]  r_hold_cnt;

    logic              r_out_valid;
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_pressed;
    logic [WORD_W-1:0] r_released;
    logic [WORD_W-1:0] r_repeat;
    logic [WORD_W-1:0] r_hold;

    logic              s_out_free;
    logic              s_adv;
    logic              s_in_take;
    logic [DIR_W-1:0]  s_dirs;
    logic [WORD_W-1:0] s_word;
    logic [WORD_W-1:0] s_pressed;
    logic              s_same;
    logic [CFG_W-1:0]  s_rep_bump;
    logic [CFG_W-1:0]  s_hold_bump;
    logic              s_rep_fire;
    logic              s_hold_fire;
    logic [CFG_W-1:0]  n_rep_cnt;
    logic [CFG_W-1:0]  n_hold_cnt;
    logic [WORD_W-1:0] n_repeat;
    logic [WORD_W-1:0] n_hold;

    pbea_dirs u_dirs (
        .i_cfg     (r_stick),
        .i_left_x  (r_lx),
        .i_left_y  (r_ly),
        .i_right_x (r_rx),
        .i_right_y (r_ry),
        .o_dirs    (s_dirs)
    );

    assign s_out_free = !r_out_valid || !i_stall;
    assign s_adv      = r_in_valid && s_out_free;
    assign o_stall    = r_in_valid && !s_out_free;
    assign s_in_take  = i_valid && !o_stall;

    always_comb begin
        s_word      = {s_dirs, r_raw};
        s_pressed   = s_word & ~r_stored_word;
        s_same      = (s_word == r_stored_word);
        s_rep_bump  = (r_rep_cnt == '1) ? r_rep_cnt : r_rep_cnt + 1'b1;
        s_hold_bump = (r_hold_cnt == '1) ? r_hold_cnt : r_hold_cnt + 1'b1;
        s_rep_fire  = s_same && (s_rep_bump >= r_delay);
        s_hold_fire = s_same && (s_hold_bump >= r_delay);
        n_repeat    = s_rep_fire ? s_word : s_pressed;
        n_hold      = s_hold_fire ? s_word : s_pressed;
        if (!s_same) begin
            n_rep_cnt  = '0;
            n_hold_cnt = '0;
        end else begin
            n_rep_cnt  = s_rep_fire ? r_reload : s_rep_bump;
            n_hold_cnt = s_hold_fire ? r_delay : s_hold_bump;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stick.center    <= CENTER_RST;
            r_stick.threshold <= THRESHOLD_RST;
            r_delay           <= DELAY_RST;
            r_reload          <= RELOAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER:    r_stick.center    <= i_cfg_data;
                CFG_THRESHOLD: r_stick.threshold <= i_cfg_data;
                CFG_DELAY:     r_delay           <= i_cfg_data;
                CFG_RELOAD:    r_reload          <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_stored_word <= '0;
            r_rep_cnt     <= '0;
            r_hold_cnt    <= '0;
        end else begin
            if (s_in_take) begin
                r_in_valid <= 1'b1;
            end else if (s_adv) begin
                r_in_valid <= 1'b0;
            end
            if (s_adv) begin
                r_out_valid   <= 1'b1;
                r_stored_word <= s_word;
                r_rep_cnt     <= n_rep_cnt;
                r_hold_cnt    <= n_hold_cnt;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_take) begin
            r_raw <= i_raw_buttons;
            r_lx  <= i_left_x;
            r_ly  <= i_left_y;
            r_rx  <= i_right_x;
            r_ry  <= i_right_y;
        end
        if (s_adv) begin
            r_word     <= s_word;
            r_pressed  <= s_pressed;
            r_released <= ~s_word & r_stored_word;
            r_repeat   <= n_repeat;
            r_hold     <= n_hold;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_button_word    = r_word;
    assign o_pressed_bits   = r_pressed;
    assign o_released_bits  = r_released;
    assign o_repeat_bits    = r_repeat;
    assign o_long_hold_bits = r_hold;

    `ASSERT_SAME(a_edges_disjoint, o_valid, (o_pressed_bits & o_released_bits) == '0, "pressed and released overlap")
    `ASSERT_NEXT(a_change_clears, s_adv && !s_same, r_rep_cnt == '0 && r_hold_cnt == '0, "counters not cleared on change")
    `ASSERT_SAME(a_stall_needs_item, o_stall, r_in_valid && r_out_valid, "input stalled without a held request")
    `ASSERT_NEXT(a_change_stores, s_adv, r_stored_word == $past(s_word), "stored word not updated")

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the button edge detect and auto-repeat core.
module tb
    import pbea_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400_000;

    localparam int LEFT_UP     = 24;
    localparam int LEFT_RIGHT  = 25;
    localparam int LEFT_DOWN   = 26;
    localparam int LEFT_LEFT   = 27;
    localparam int RIGHT_UP    = 28;
    localparam int RIGHT_RIGHT = 29;
    localparam int RIGHT_DOWN  = 30;
    localparam int RIGHT_LEFT  = 31;

    typedef struct packed {
        logic [RAW_W-1:0]  raw;
        logic [AXIS_W-1:0] lx;
        logic [AXIS_W-1:0] ly;
        logic [AXIS_W-1:0] rx;
        logic [AXIS_W-1:0] ry;
    } t_poll;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] pressed;
        logic [WORD_W-1:0] released;
        logic [WORD_W-1:0] rep;
        logic [WORD_W-1:0] hold;
    } t_poll_result;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [1:0]        i_cfg_idx     = CFG_CENTER;
    logic [CFG_W-1:0]  i_cfg_data    = '0;
    logic              i_valid       = 1'b0;
    logic              o_stall;
    logic [RAW_W-1:0]  i_raw_buttons = '0;
    logic [AXIS_W-1:0] i_left_x      = '0;
    logic [AXIS_W-1:0] i_left_y      = '0;
    logic [AXIS_W-1:0] i_right_x     = '0;
    logic [AXIS_W-1:0] i_right_y     = '0;
    logic              o_valid;
    logic              i_stall       = 1'b0;
    logic [WORD_W-1:0] o_button_word;
    logic [WORD_W-1:0] o_pressed_bits;
    logic [WORD_W-1:0] o_released_bits;
    logic [WORD_W-1:0] o_repeat_bits;
    logic [WORD_W-1:0] o_long_hold_bits;

    logic [CFG_W-1:0]  cfg_center    = CENTER_RST;
    logic [CFG_W-1:0]  cfg_threshold = THRESHOLD_RST;
    logic [CFG_W-1:0]  cfg_delay     = DELAY_RST;
    logic [CFG_W-1:0]  cfg_reload    = RELOAD_RST;
    logic [WORD_W-1:0] held_word     = '0;
    logic [CFG_W-1:0]  repeat_cnt    = '0;
    logic [CFG_W-1:0]  hold_cnt      = '0;

    t_poll_result due_results[$];
    int           mismatches    = 0;
    int           src_idle_pct  = 0;
    int           snk_stall_pct = 0;
    int unsigned  cycles        = 0;

    pad_button_edge_autorepeat_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_raw_buttons    (i_raw_buttons),
        .i_left_x         (i_left_x),
        .i_left_y         (i_left_y),
        .i_right_x        (i_right_x),
        .i_right_y        (i_right_y),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_button_word    (o_button_word),
        .o_pressed_bits   (o_pressed_bits),
        .o_released_bits  (o_released_bits),
        .o_repeat_bits    (o_repeat_bits),
        .o_long_hold_bits (o_long_hold_bits)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < snk_stall_pct);
    end

    // Returns {high side, low side} for one stick axis.
    function automatic logic [1:0] axis_dir(input logic [AXIS_W-1:0] axis);
        int pos;
        int lo;
        int hi;
        pos = int'(axis);
        lo  = int'(cfg_center) - int'(cfg_threshold);
        hi  = int'(cfg_center) + int'(cfg_threshold);
        if (pos < lo) return 2'b01;
        if (pos > hi) return 2'b10;
        return 2'b00;
    endfunction

    function automatic void track_poll(input t_poll p);
        logic [WORD_W-1:0] word;
        logic [1:0]        d;
        t_poll_result      r;
        word = {{DIR_W{1'b0}}, p.raw};
        d = axis_dir(p.ly);
        word[LEFT_UP]    = d[0];
        word[LEFT_DOWN]  = d[1];
        d = axis_dir(p.lx);
        word[LEFT_LEFT]  = d[0];
        word[LEFT_RIGHT] = d[1];
        d = axis_dir(p.ry);
        word[RIGHT_UP]   = d[0];
        word[RIGHT_DOWN] = d[1];
        d = axis_dir(p.rx);
        word[RIGHT_LEFT] = d[0];
        word[RIGHT_RIGHT] = d[1];

        r.word     = word;
        r.pressed  = word & ~held_word;
        r.released = ~word & held_word;
        r.rep      = r.pressed;
        r.hold     = r.pressed;

        if (word == held_word) begin
            repeat_cnt = (repeat_cnt == 8'hFF) ? repeat_cnt : repeat_cnt + 8'd1;
            if (repeat_cnt >= cfg_delay) begin
                r.rep      = word;
                repeat_cnt = cfg_reload;
            end
            hold_cnt = (hold_cnt == 8'hFF) ? hold_cnt : hold_cnt + 8'd1;
            if (hold_cnt >= cfg_delay) begin
                r.hold   = word;
                hold_cnt = cfg_delay;
            end
        end else begin
            repeat_cnt = '0;
            hold_cnt   = '0;
            held_word  = word;
        end
        due_results.push_back(r);
    endfunction

    function automatic t_poll make_poll(input logic [RAW_W-1:0] raw,
                                        input logic [AXIS_W-1:0] lx, ly, rx, ry);
        t_poll p;
        p.raw = raw;
        p.lx  = lx;
        p.ly  = ly;
        p.rx  = rx;
        p.ry  = ry;
        return p;
    endfunction

    // Favor axis values on both sides of each threshold edge.
    function automatic logic [AXIS_W-1:0] pick_axis();
        int lo;
        int hi;
        int pos;
        lo = int'(cfg_center) - int'(cfg_threshold);
        hi = int'(cfg_center) + int'(cfg_threshold);
        case ($urandom_range(0, 7))
            0: pos = lo - 1;
            1: pos = lo;
            2: pos = hi;
            3: pos = hi + 1;
            4: pos = int'(cfg_center);
            default: pos = $urandom_range(0, 255);
        endcase
        if (pos < 0 || pos > 255) pos = $urandom_range(0, 255);
        return AXIS_W'(pos);
    endfunction

    function automatic t_poll random_poll();
        logic [RAW_W-1:0] raw;
        case ($urandom_range(0, 3))
            0: raw = '0;
            1: raw = RAW_W'(1) << $urandom_range(0, RAW_W - 1);
            default: raw = RAW_W'($urandom);
        endcase
        return make_poll(raw, pick_axis(), pick_axis(), pick_axis(), pick_axis());
    endfunction

    task automatic send_poll(input t_poll p);
        logic stalled;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_raw_buttons <= p.raw;
        i_left_x      <= p.lx;
        i_left_y      <= p.ly;
        i_right_x     <= p.rx;
        i_right_y     <= p.ry;
        do begin
            @(negedge i_clk);
            stalled = o_stall;
            @(posedge i_clk);
        end while (stalled);
        track_poll(p);
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (due_results.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] center, thr, dly, rld);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CENTER;
        i_cfg_data <= center;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_THRESHOLD;
        i_cfg_data <= thr;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DELAY;
        i_cfg_data <= dly;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RELOAD;
        i_cfg_data <= rld;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_center    = center;
        cfg_threshold = thr;
        cfg_delay     = dly;
        cfg_reload    = rld;
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want, got);
        if (got !== want) begin
            $display("%0t %s: expected %08h, got %08h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin
        t_poll_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_results.size() == 0) begin
                $display("%0t unexpected request: expected none, got word %08h",
                         $time, o_button_word);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("button_word", want.word, o_button_word);
                check_field("pressed_bits", want.pressed, o_pressed_bits);
                check_field("released_bits", want.released, o_released_bits);
                check_field("repeat_bits", want.rep, o_repeat_bits);
                check_field("long_hold_bits", want.hold, o_long_hold_bits);
            end
        end
    end

    // Reset settings: up or left below 64, down or right above 192.
    task automatic test_edge_extremes();
        send_poll(make_poll('0, 8'd128, 8'd128, 8'd128, 8'd128));
        send_poll(make_poll('1, 8'd0, 8'd0, 8'd0, 8'd0));
        send_poll(make_poll('1, 8'd255, 8'd255, 8'd255, 8'd255));
        send_poll(make_poll('0, 8'd63, 8'd63, 8'd63, 8'd63));
        send_poll(make_poll('0, 8'd64, 8'd64, 8'd192, 8'd192));
        send_poll(make_poll('0, 8'd193, 8'd193, 8'd193, 8'd193));
        send_poll(make_poll(24'hA5A5A5, 8'd0, 8'd255, 8'd255, 8'd0));
        send_poll(make_poll(24'hA5A5A5, 8'd0, 8'd255, 8'd255, 8'd0));
    endtask

    // Bounds below zero or above full scale never set a direction.
    task automatic test_threshold_range();
        wait_results();
        load_settings(8'd0, 8'd255, DELAY_RST, RELOAD_RST);
        send_poll(make_poll(24'h000001, 8'd0, 8'd0, 8'd255, 8'd255));
        send_poll(make_poll(24'h000002, 8'd255, 8'd255, 8'd0, 8'd0));
        wait_results();
        load_settings(8'd255, 8'd255, DELAY_RST, RELOAD_RST);
        send_poll(make_poll(24'h000004, 8'd0, 8'd255, 8'd0, 8'd255));
        wait_results();
        load_settings(8'd255, 8'd0, DELAY_RST, RELOAD_RST);
        send_poll(make_poll(24'h800000, 8'd254, 8'd255, 8'd255, 8'd254));
        send_poll(make_poll(24'h800000, 8'd255, 8'd254, 8'd254, 8'd255));
    endtask

    task automatic test_delay_zero();
        t_poll p;
        p = make_poll(24'h0F00F0, 8'd128, 8'd128, 8'd128, 8'd128);
        wait_results();
        load_settings(CENTER_RST, THRESHOLD_RST, 8'd0, 8'd0);
        repeat (3) send_poll(p);
    endtask

    task automatic test_reload_not_below_delay();
        t_poll p;
        p = make_poll(24'h123456, 8'd10, 8'd128, 8'd250, 8'd128);
        wait_results();
        load_settings(CENTER_RST, THRESHOLD_RST, 8'd2, 8'd5);
        repeat (4) send_poll(p);
    endtask

    // Counters keep their value across the idle gap; the lower delay fires at once.
    task automatic test_delay_lowered();
        t_poll p;
        p = make_poll(24'h00FF00, 8'd128, 8'd20, 8'd128, 8'd128);
        wait_results();
        load_settings(CENTER_RST, THRESHOLD_RST, 8'd10, 8'd6);
        repeat (3) send_poll(p);
        wait_results();
        load_settings(CENTER_RST, THRESHOLD_RST, 8'd2, 8'd6);
        repeat (2) send_poll(p);
    endtask

    // Counters pin at full scale instead of wrapping.
    task automatic test_long_hold_saturation();
        t_poll p;
        wait_results();
        load_settings(CENTER_RST, THRESHOLD_RST, 8'd255, 8'd255);
        p = random_poll();
        p.raw[0] = 1'b1;
        repeat (270) send_poll(p);
    endtask

    task automatic test_random_phase(input int src_pct, input int snk_pct, input int n_polls);
        logic [CFG_W-1:0] center;
        logic [CFG_W-1:0] thr;
        logic [CFG_W-1:0] dly;
        logic [CFG_W-1:0] rld;
        t_poll            base;
        int               sent;
        int               run_len;
        wait_results();
        case ($urandom_range(0, 5))
            0: center = 8'd0;
            1: center = 8'd255;
            default: center = CFG_W'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 5))
            0: thr = 8'd0;
            1: thr = 8'd255;
            default: thr = CFG_W'($urandom_range(0, 100));
        endcase
        case ($urandom_range(0, 9))
            0: dly = 8'd0;
            1: dly = CFG_W'($urandom_range(0, 255));
            default: dly = CFG_W'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 4))
            0: rld = CFG_W'($urandom_range(0, 255));
            default: rld = (dly == 0) ? 8'd0 : CFG_W'($urandom_range(0, dly - 1));
        endcase
        load_settings(center, thr, dly, rld);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;

        sent = 0;
        while (sent < n_polls) begin
            base    = random_poll();
            run_len = ($urandom_range(0, 9) < 3) ? 1 : $urandom_range(2, 30);
            repeat (run_len) begin
                send_poll(base);
                sent++;
                if ($urandom_range(0, 19) == 0)
                    base.raw[$urandom_range(0, RAW_W - 1)] ^= 1'b1;
                if ($urandom_range(0, 199) == 0)
                    wait_results();
            end
        end
        src_idle_pct  = 0;
        snk_stall_pct = 0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_extremes();
        test_threshold_range();
        test_delay_zero();
        test_reload_not_below_delay();
        test_delay_lowered();
        test_long_hold_saturation();
        test_random_phase(0, 0, 380);
        test_random_phase(53, 0, 380);
        test_random_phase(0, 53, 380);
        test_random_phase(21, 21, 380);

        wait_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- pad_button_edge_autorepeat_core.f -----
+incdir+sv
sv/pbea_pkg.sv
sv/pbea_dirs.sv
sv/pad_button_edge_autorepeat_core.sv
test/tb.sv
